@@ rtl/core/aoc_pkg.sv @@
// aoc_pkg: shared types and codes for the accelerometer orientation classifier
// used by aoc_div_lane, aoc_merge, aoc_checker and accel_orientation_classifier
// no dependencies
package aoc_pkg;

  // width of one sample axis and of one batch average
  localparam int unsigned DATA_W = 16;
  // width of the tilt thresholds
  localparam int unsigned LEVEL_W = 15;
  // configuration port index width
  localparam int unsigned CFG_IDX_W = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FLIP_LEVEL      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FULL_TILT_LEVEL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_TILT_LEVEL = 2'd2;

  // reset values of the thresholds, Q8.8
  localparam logic signed [DATA_W-1:0] FLIP_LEVEL_RST      = -16'sd2048;
  localparam logic [LEVEL_W-1:0]       FULL_TILT_LEVEL_RST = 15'd2304;
  localparam logic [LEVEL_W-1:0]       HALF_TILT_LEVEL_RST = 15'd1075;

  // orientation codes
  typedef enum logic [2:0] {
    ORI_NONE        = 3'd0,
    ORI_UPSIDE_DOWN = 3'd1,
    ORI_TILT_RIGHT  = 3'd2,
    ORI_TILT_LEFT   = 3'd3,
    ORI_HALF_RIGHT  = 3'd4,
    ORI_HALF_LEFT   = 3'd5
  } ori_t;

  // threshold set handed to the merge stage
  typedef struct packed {
    logic signed [DATA_W-1:0] flip_level;
    logic [LEVEL_W-1:0]       full_tilt_level;
    logic [LEVEL_W-1:0]       half_tilt_level;
  } level_cfg_t;

endpackage

@@ rtl/core/accel_orientation_classifier.sv @@
// accel_orientation_classifier: top level, batch accumulation, three divide
// lanes and the orientation merge stage
// depends on aoc_pkg, aoc_div_lane, aoc_merge
//
// usage:
//   input items: one three-axis sample each, taken at a clock edge with start
//   high and busy low. sample_ok low adds nothing but still counts. an item
//   with batch_end set, or the one that brings the batch to MAX_SAMPLES,
//   closes the batch.
//   an item that does not close a batch leaves busy low.
//   a closing item starts the three divide lanes (one quotient bit a cycle
//   over the SUM_W-bit sums, SUM_W = 16 + clog2(MAX_SAMPLES+1), 22 by
//   default); busy stays high until the result item appears on the out_
//   ports, marked by out_valid for one cycle, once the lanes are done and
//   the merge stage has registered it. busy is low while it is shown, so
//   the next item can be taken at the edge that takes the result.
//   the receiver cannot stall; each result is on the ports for one cycle.
//   configuration: cfg_valid/cfg_ready with cfg_index and cfg_data, to be
//   written only while idle; cfg_ready is always high; unknown indexes are
//   dropped.
//   reset (rst_n low, synchronous) clears the sums, the count and the
//   thresholds to their defaults.
module accel_orientation_classifier #(
  parameter int unsigned MAX_SAMPLES = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [aoc_pkg::DATA_W-1:0]    in_accel_x,
  input  logic signed [aoc_pkg::DATA_W-1:0]    in_accel_y,
  input  logic signed [aoc_pkg::DATA_W-1:0]    in_accel_z,
  input  logic                                 in_sample_ok,
  input  logic                                 in_batch_end,
  output logic                                 out_valid,
  output logic [2:0]                           out_orientation,
  output logic signed [aoc_pkg::DATA_W-1:0]    out_mean_x,
  output logic signed [aoc_pkg::DATA_W-1:0]    out_mean_y,
  output logic signed [aoc_pkg::DATA_W-1:0]    out_mean_z,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [aoc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [aoc_pkg::DATA_W-1:0]           cfg_data
);
  import aoc_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned SUM_W = DATA_W + CNT_W;

  typedef enum logic {
    ST_ACC,
    ST_DIV
  } state_t;

  state_t                   state_r;
  logic signed [SUM_W-1:0]  sum_x_r, sum_y_r, sum_z_r;
  logic signed [SUM_W-1:0]  sum_x_nxt, sum_y_nxt, sum_z_nxt;
  logic [CNT_W-1:0]         count_r, count_nxt;
  level_cfg_t               levels_r;
  logic                     accept;
  logic                     close;
  logic                     done_x, done_y, done_z;
  logic signed [DATA_W-1:0] avg_x, avg_y, avg_z;

  assign accept    = start && (state_r == ST_ACC);
  assign busy      = (state_r != ST_ACC);
  assign cfg_ready = 1'b1;

  // next sums and count for the accepted item
  always_comb begin
    sum_x_nxt = sum_x_r;
    sum_y_nxt = sum_y_r;
    sum_z_nxt = sum_z_r;
    if (in_sample_ok) begin
      sum_x_nxt = sum_x_r + SUM_W'(in_accel_x);
      sum_y_nxt = sum_y_r + SUM_W'(in_accel_y);
      sum_z_nxt = sum_z_r + SUM_W'(in_accel_z);
    end
    count_nxt = count_r + 1'b1;
  end

  assign close = in_batch_end || (count_nxt == CNT_W'(MAX_SAMPLES));

  // batch control and accumulators
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_ACC;
      sum_x_r <= '0;
      sum_y_r <= '0;
      sum_z_r <= '0;
      count_r <= '0;
    end else begin
      case (state_r)
        ST_ACC: begin
          if (accept) begin
            if (close) begin
              state_r <= ST_DIV;
              sum_x_r <= '0;
              sum_y_r <= '0;
              sum_z_r <= '0;
              count_r <= '0;
            end else begin
              sum_x_r <= sum_x_nxt;
              sum_y_r <= sum_y_nxt;
              sum_z_r <= sum_z_nxt;
              count_r <= count_nxt;
            end
          end
        end
        ST_DIV: begin
          if (done_x) begin
            state_r <= ST_ACC;
          end
        end
        default: begin
          state_r <= ST_ACC;
        end
      endcase
    end
  end

  // threshold registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      levels_r.flip_level      <= FLIP_LEVEL_RST;
      levels_r.full_tilt_level <= FULL_TILT_LEVEL_RST;
      levels_r.half_tilt_level <= HALF_TILT_LEVEL_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_FLIP_LEVEL:      levels_r.flip_level      <= $signed(cfg_data);
        CFG_FULL_TILT_LEVEL: levels_r.full_tilt_level <= cfg_data[LEVEL_W-1:0];
        CFG_HALF_TILT_LEVEL: levels_r.half_tilt_level <= cfg_data[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  // one divide lane per axis, all with the same latency
  aoc_div_lane #(.SUM_W(SUM_W), .CNT_W(CNT_W)) u_lane_x (
    .clk(clk), .rst_n(rst_n), .go(accept && close),
    .dividend(sum_x_nxt), .divisor(count_nxt),
    .done(done_x), .quotient(avg_x)
  );

  aoc_div_lane #(.SUM_W(SUM_W), .CNT_W(CNT_W)) u_lane_y (
    .clk(clk), .rst_n(rst_n), .go(accept && close),
    .dividend(sum_y_nxt), .divisor(count_nxt),
    .done(done_y), .quotient(avg_y)
  );

  aoc_div_lane #(.SUM_W(SUM_W), .CNT_W(CNT_W)) u_lane_z (
    .clk(clk), .rst_n(rst_n), .go(accept && close),
    .dividend(sum_z_nxt), .divisor(count_nxt),
    .done(done_z), .quotient(avg_z)
  );

  // merge the lanes into one result item
  aoc_merge u_merge (
    .clk(clk),
    .rst_n(rst_n),
    .lanes_done(done_x && done_y && done_z),
    .avg_x(avg_x),
    .avg_y(avg_y),
    .avg_z(avg_z),
    .levels(levels_r),
    .res_valid(out_valid),
    .res_orientation(out_orientation),
    .res_mean_x(out_mean_x),
    .res_mean_y(out_mean_y),
    .res_mean_z(out_mean_z)
  );

endmodule

@@ rtl/core/aoc_div_lane.sv @@
// aoc_div_lane: one axis lane, signed sum divided by sample count,
// restoring divide one quotient bit per cycle, truncating toward zero
// depends on aoc_pkg
module aoc_div_lane #(
  parameter int unsigned SUM_W = 22,
  parameter int unsigned CNT_W = 6
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          go,
  input  logic signed [SUM_W-1:0]       dividend,
  input  logic [CNT_W-1:0]              divisor,
  output logic                          done,
  output logic signed [aoc_pkg::DATA_W-1:0] quotient
);
  import aoc_pkg::*;

  localparam int unsigned STEP_W = $clog2(SUM_W + 1);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [SUM_W-1:0]  quo_r, quo_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic [CNT_W-1:0]  div_r, div_nxt;
  logic              neg_r, neg_nxt;
  logic [CNT_W:0]    trial;
  logic [CNT_W:0]    trial_sub;
  logic              fits;
  logic [DATA_W-1:0] quo_low;

  // one restoring step
  assign trial     = {rem_r, quo_r[SUM_W-1]};
  assign fits      = trial >= {1'b0, div_r};
  assign trial_sub = trial - {1'b0, div_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    neg_nxt  = neg_r;
    if (go) begin
      // load magnitude and sign
      busy_nxt = 1'b1;
      step_nxt = STEP_W'(SUM_W);
      quo_nxt  = dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;
      rem_nxt  = '0;
      div_nxt  = divisor;
      neg_nxt  = dividend[SUM_W-1];
    end else if (busy_r) begin
      rem_nxt  = fits ? trial_sub[CNT_W-1:0] : trial[CNT_W-1:0];
      quo_nxt  = {quo_r[SUM_W-2:0], fits};
      step_nxt = step_r - 1'b1;
      if (step_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
    neg_r <= neg_nxt;
  end

  // restore the sign, the average always fits the sample width
  assign quo_low  = quo_r[DATA_W-1:0];
  assign quotient = neg_r ? -$signed(quo_low) : $signed(quo_low);
  assign done     = done_r;

endmodule

@@ rtl/core/aoc_merge.sv @@
// aoc_merge: combines the three lane averages into the orientation code
// and registers the result item with its strobe
// depends on aoc_pkg
module aoc_merge (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              lanes_done,
  input  logic signed [aoc_pkg::DATA_W-1:0] avg_x,
  input  logic signed [aoc_pkg::DATA_W-1:0] avg_y,
  input  logic signed [aoc_pkg::DATA_W-1:0] avg_z,
  input  aoc_pkg::level_cfg_t               levels,
  output logic                              res_valid,
  output logic [2:0]                        res_orientation,
  output logic signed [aoc_pkg::DATA_W-1:0] res_mean_x,
  output logic signed [aoc_pkg::DATA_W-1:0] res_mean_y,
  output logic signed [aoc_pkg::DATA_W-1:0] res_mean_z
);
  import aoc_pkg::*;

  localparam int unsigned CMP_W = DATA_W + 1;

  logic signed [CMP_W-1:0] x_e, y_e, full_p, full_n, half_p, half_n;
  ori_t                    ori;
  logic                    valid_r;
  ori_t                    ori_r;
  logic signed [DATA_W-1:0] mx_r, my_r, mz_r;

  // thresholds and averages in one signed compare width
  assign x_e    = CMP_W'(avg_x);
  assign y_e    = CMP_W'(avg_y);
  assign full_p = $signed({2'b00, levels.full_tilt_level});
  assign half_p = $signed({2'b00, levels.half_tilt_level});
  assign full_n = -full_p;
  assign half_n = -half_p;

  // priority classification
  always_comb begin
    if (avg_z <= levels.flip_level) begin
      ori = ORI_UPSIDE_DOWN;
    end else if (y_e >= full_p) begin
      ori = ORI_TILT_RIGHT;
    end else if (y_e <= full_n) begin
      ori = ORI_TILT_LEFT;
    end else if (y_e >= half_p) begin
      ori = ORI_HALF_RIGHT;
    end else if (y_e <= half_n) begin
      ori = ORI_HALF_LEFT;
    end else if (x_e >= half_p && x_e < full_p) begin
      ori = ORI_HALF_RIGHT;
    end else if (x_e <= half_n && x_e > full_n) begin
      ori = ORI_HALF_LEFT;
    end else begin
      ori = ORI_NONE;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= lanes_done;
    end
    if (lanes_done) begin
      ori_r <= ori;
      mx_r  <= avg_x;
      my_r  <= avg_y;
      mz_r  <= avg_z;
    end
  end

  assign res_valid       = valid_r;
  assign res_orientation = ori_r;
  assign res_mean_x      = mx_r;
  assign res_mean_y      = my_r;
  assign res_mean_z      = mz_r;

endmodule

@@ rtl/core/aoc_checker.sv @@
// aoc_checker: port-level checks for accel_orientation_classifier, bound
// to the top level below
// depends on aoc_pkg
module aoc_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           start,
  input logic                           busy,
  input logic                           in_batch_end,
  input logic                           out_valid,
  input logic [2:0]                     out_orientation
);
  import aoc_pkg::*;

  // a closing item makes the block busy
  a_close_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_batch_end |=> busy)
    else $error("closing item did not start the divide");

  // a result follows a busy divide
  a_res_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result item without a preceding divide");

  // the block is ready again when the result shows
  a_res_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("busy while result item is shown");

  // results are single-cycle strobes, never back to back
  a_res_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  // orientation code is in range
  a_ori_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_orientation <= 3'd5)
    else $error("orientation code out of range");

endmodule

bind accel_orientation_classifier aoc_checker u_aoc_checker (
  .clk(clk),
  .rst_n(rst_n),
  .start(start),
  .busy(busy),
  .in_batch_end(in_batch_end),
  .out_valid(out_valid),
  .out_orientation(out_orientation)
);
